[rtl/uampq_pkg.sv]
// shared types and constants of the unsorted-array min priority queue
// no dependencies; used by uampq_ctrl, uampq_dpath and the top level
package uampq_pkg;

    // default number of held edges
    localparam int CAPACITY_DEF = 32;

    // field widths
    localparam int VERTEX_W = 16;
    localparam int PRIO_W   = 32;
    localparam int ENTRY_W  = 2 * VERTEX_W + PRIO_W;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 72;

    // request kinds carried on the slave-side tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    accept;
        logic    ins_write;
        logic    scan;
        logic    wb;
        logic    load_out;
        t_status status;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/uampq_ctrl.sv]
// controller state machine of the min priority queue
// depends on uampq_pkg; drives uampq_dpath through t_dp_cmd
module uampq_ctrl
    import uampq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_req,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WB,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_ready  = 1'b0;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_RESULT;
                    if (i_req == REQ_INSERT) begin
                        if (i_stat.count_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.ins_write = 1'b1;
                            n_status = ST_DONE;
                        end
                    end else if (i_stat.count_zero) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status = ST_DONE;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and status code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

[rtl/uampq_dpath.sv]
// datapath of the min priority queue: entry memory, count, scan and output register
// depends on uampq_pkg; commanded by uampq_ctrl
module uampq_dpath
    import uampq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req,
    input  logic [S_DATA_W-1:0] i_data,
    input  logic                i_out_ready,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_out_valid,
    output logic [1:0]          o_out_status,
    output logic [M_DATA_W-1:0] o_out_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // entry layout: start in the low bits, then end, then priority
    logic [ENTRY_W-1:0] r_mem [CAPACITY];

    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_scan_idx;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_cmp_vld;
    logic [ENTRY_W-1:0]  r_rd_data;
    logic [IW-1:0]       r_best_idx;
    logic [ENTRY_W-1:0]  r_best;
    logic                r_req_del;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [M_DATA_W-1:0] r_out_data;

    logic                     w_better;
    logic signed [PRIO_W-1:0] w_rd_prio;
    logic signed [PRIO_W-1:0] w_best_prio;
    logic [CW-1:0]            w_last;
    logic                     w_take_best;

    assign w_rd_prio   = r_rd_data[ENTRY_W-1 -: PRIO_W];
    assign w_best_prio = r_best[ENTRY_W-1 -: PRIO_W];
    assign w_better    = (r_cmp_idx == '0) || (w_rd_prio < w_best_prio);
    assign w_last      = r_count - CW'(1);
    assign w_take_best = r_req_del && (i_cmd.status == ST_DONE);

    // status to the controller
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_full = (r_count == CW'(CAPACITY));
    assign o_stat.scan_last  = (CW'(r_scan_idx) == w_last);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            r_mem[r_count[IW-1:0]] <= i_data[ENTRY_W-1:0];
        end else if (i_cmd.wb) begin
            r_mem[r_best_idx] <= r_rd_data;
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_write) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.wb) begin
            r_count <= w_last;
        end
    end

    // scan index and compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
        end
        if (i_cmd.accept) begin
            r_scan_idx <= '0;
            r_req_del  <= i_req;
        end else if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + IW'(1);
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_scan_idx;
        end
    end

    // running minimum, first entry wins a tie
    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && w_better) begin
            r_best_idx <= r_cmp_idx;
            r_best     <= r_rd_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.status;
            r_out_data   <= {{(M_DATA_W-ENTRY_W-1){1'b0}}, (r_count == '0),
                             (w_take_best ? r_best : ENTRY_W'(0))};
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;

endmodule

[rtl/unsorted_array_min_priority_queue.sv]
// Min-priority queue of graph edges kept unsorted in a CAPACITY-entry memory.
// An insert appends at the tail. A delete-min scans the held entries one
// memory read per cycle, keeping the first entry with the smallest signed
// priority, then moves the last entry into the freed slot; the entry memory
// has a single read port. One request is worked at a time; the result sits
// in an output register, so the next request is taken while a result waits.
// Every request gives exactly one result word; inserts at full capacity are
// dropped with a full status.
// depends on uampq_pkg, uampq_ctrl and uampq_dpath
module unsorted_array_min_priority_queue
    import uampq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // edge_start[15:0], edge_end[31:16], priority_req[63:32]
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_start[15:0], out_end[31:16], out_cost[63:32], now_empty[64], zero[71:65]
    output logic [M_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]          m_tuser
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing of insert, scan and write-back
    uampq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_req   (s_tuser),
        .o_ready (s_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // entry memory, minimum search and result register
    uampq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (s_tuser),
        .i_data       (s_tdata),
        .i_out_ready  (m_tready),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (m_tvalid),
        .o_out_status (m_tuser),
        .o_out_data   (m_tdata)
    );

endmodule
